### sv/dse_pkg.sv
// Package for the deck shuffle engine: state encoding, command and status codes,
// field widths and the request/response types of the modulo unit.
// No dependencies.
package dse_pkg;

  localparam int SizeW     = 7;   // deck_size register and modulo divisor width
  localparam int PosW      = 6;
  localparam int RankW     = 4;
  localparam int SuitW     = 2;
  localparam int CardW     = RankW + SuitW;
  localparam int DividendW = 16;
  localparam int CountW    = $clog2(DividendW + 1);
  localparam int StatusW   = 2;
  localparam int CmdW      = 2;

  localparam logic [SizeW-1:0] DeckSizeReset = 7'd52;

  localparam logic [CmdW-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CmdW-1:0] CMD_SHUFFLE = 2'd1;
  localparam logic [CmdW-1:0] CMD_DRAW    = 2'd2;

  localparam logic [StatusW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatusW-1:0] STAT_PASS_DONE = 2'd1;
  localparam logic [StatusW-1:0] STAT_RANGE     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_RD_I,
    S_RD_J,
    S_WR_I,
    S_WR_J,
    S_DRAW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [SizeW-1:0]     divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [SizeW-1:0] rem;
  } mod_rsp_t;

endpackage

### sv/dse_mod_unit.sv
// Iterative remainder unit: restoring division, one dividend bit per cycle.
// Depends on dse_pkg.
module dse_mod_unit import dse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic                 busy_r;
  logic [CountW-1:0]    cnt_r;
  logic [DividendW-1:0] dvd_r;
  logic [SizeW-1:0]     dsr_r;
  logic [SizeW-1:0]     rem_r;

  logic [SizeW:0]   trial;
  logic             fits;
  logic [SizeW-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[DividendW-1]};
    fits    = trial >= {1'b0, dsr_r};
    // remainder stays below the divisor, so the top bit drops
    rem_nxt = fits ? SizeW'(trial - {1'b0, dsr_r}) : SizeW'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CountW'(DividendW);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r && cnt_r != '0) begin
      dvd_r <= {dvd_r[DividendW-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = busy_r && (cnt_r == '0);
  assign rsp.rem  = rem_r;

endmodule

### sv/dse_deck_mem.sv
// Single-port deck store, one access per cycle, registered read data.
// Depends on dse_pkg.
module dse_deck_mem import dse_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [CardW-1:0] wdata,
  output logic [CardW-1:0] rdata
);

  logic [CardW-1:0] mem [DEPTH];
  logic [CardW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/deck_shuffle_engine_unit.sv
// Deck shuffle engine, top level: command sequencer, deck store, modulo unit.
// Depends on dse_pkg, dse_mod_unit, dse_deck_mem.
//
// Input channel in_*: one command per beat, command in in_tuser. Output channel
// out_*: exactly one result beat per command, status in out_tuser. cfg_wr_en
// writes deck_size (cards in use, values above MAX_CARDS act as MAX_CARDS).
// Load writes one card and restarts the shuffle pass. Each shuffle beat makes
// one Fisher-Yates swap, i counting down from size-1 to 1; status 1 marks the
// last swap. Draw reads one card. Positions at or beyond the size answer
// status 2 and change nothing.
// One command at a time: in_tready is high only while the sequencer is idle.
// Load, unused commands, out-of-range draws and shuffles on a deck under two cards
// go from decode straight to the result state; a draw adds a read state; a
// shuffle step waits for the bit-serial remainder (random mod (i+1)) and then
// makes four single-port memory accesses for the swap. out_tvalid rises in the
// same cycle as in_tready returns.
// The output register frees the sequencer: the next command is taken while a
// result waits, and a second result waits until out_tready takes the first.
// Reset empties the output, stops any pass and sets deck_size to 52; the deck
// contents are undefined until loaded.
module deck_shuffle_engine_unit import dse_pkg::*; #(
  parameter int MAX_CARDS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // position[5:0], card_rank[9:6],
                                           // card_suit[11:10], random_value[27:12]
  input  logic [CmdW-1:0]      in_tuser,   // command
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // drawn_rank[3:0], drawn_suit[5:4]
  output logic [StatusW-1:0]   out_tuser,  // status
  input  logic                 cfg_wr_en,
  input  logic [SizeW-1:0]     cfg_wr_data
);

  localparam int AW = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
  localparam int CW = (AW > SizeW) ? AW : SizeW;

  state_t state_r, state_nxt;

  logic [SizeW-1:0]     deck_size_r;
  logic [CmdW-1:0]      cmd_r;
  logic [PosW-1:0]      pos_r;
  logic [CardW-1:0]     card_r;
  logic [DividendW-1:0] rnd_r;

  logic [AW-1:0]      swap_index_r, swap_index_nxt;
  logic [AW-1:0]      i_r, i_nxt;
  logic [AW-1:0]      j_r, j_nxt;
  logic [CardW-1:0]   held_r, held_nxt;
  logic [CardW-1:0]   res_card_r, res_card_nxt;
  logic [StatusW-1:0] res_status_r, res_status_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [CardW-1:0]   out_card_r, out_card_nxt;
  logic [StatusW-1:0] out_status_r, out_status_nxt;

  logic [SizeW-1:0] n_cur;
  logic             pos_ok;
  logic [CW-1:0]    swap_ext;
  logic [CW-1:0]    i_sel;
  logic             out_free;

  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [CardW-1:0] mem_wdata;
  logic [CardW-1:0] mem_rdata;
  mod_req_t         mod_req;
  mod_rsp_t         mod_rsp;

  dse_mod_unit u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mod_req),
    .rsp  (mod_rsp)
  );

  dse_deck_mem #(
    .DEPTH(MAX_CARDS),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_comb begin
    n_cur    = (int'(deck_size_r) > MAX_CARDS) ? SizeW'(MAX_CARDS) : deck_size_r;
    pos_ok   = {1'b0, pos_r} < n_cur;
    swap_ext = CW'(swap_index_r);
    // no pass running, or the size shrank under it: start from the top
    if (swap_ext == '0 || swap_ext >= CW'(n_cur)) begin
      i_sel = CW'(n_cur) - CW'(1);
    end else begin
      i_sel = swap_ext;
    end
    out_free = !out_valid_r || out_tready;
  end

  assign in_tready = (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_DECODE;
      S_DECODE: begin
        case (cmd_r)
          CMD_SHUFFLE: state_nxt = (n_cur < SizeW'(2)) ? S_DONE : S_DIV;
          CMD_DRAW:    state_nxt = pos_ok ? S_DRAW : S_DONE;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_DIV:    if (mod_rsp.done) state_nxt = S_RD_I;
      S_RD_I:   state_nxt = S_RD_J;
      S_RD_J:   state_nxt = S_WR_I;
      S_WR_I:   state_nxt = S_WR_J;
      S_WR_J:   state_nxt = S_DONE;
      S_DRAW:   state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    mem_we           = 1'b0;
    mem_addr         = AW'(pos_r);
    mem_wdata        = card_r;
    mod_req.start    = 1'b0;
    mod_req.dividend = rnd_r;
    mod_req.divisor  = SizeW'(i_sel + CW'(1));
    swap_index_nxt   = swap_index_r;
    i_nxt            = i_r;
    j_nxt            = j_r;
    held_nxt         = held_r;
    res_card_nxt     = res_card_r;
    res_status_nxt   = res_status_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_card_nxt     = out_card_r;
    out_status_nxt   = out_status_r;
    case (state_r)
      S_DECODE: begin
        res_card_nxt   = '0;
        res_status_nxt = STAT_OK;
        case (cmd_r)
          CMD_LOAD: begin
            if (pos_ok) begin
              mem_we         = 1'b1;
              swap_index_nxt = '0;
            end else begin
              res_status_nxt = STAT_RANGE;
            end
          end
          CMD_SHUFFLE: begin
            if (n_cur < SizeW'(2)) begin
              swap_index_nxt = '0;
              res_status_nxt = STAT_PASS_DONE;
            end else begin
              mod_req.start = 1'b1;
              i_nxt         = AW'(i_sel);
            end
          end
          CMD_DRAW: begin
            if (!pos_ok) res_status_nxt = STAT_RANGE;
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (mod_rsp.done) j_nxt = AW'(mod_rsp.rem);
      end
      S_RD_I: mem_addr = i_r;
      S_RD_J: begin
        mem_addr = j_r;
        held_nxt = mem_rdata;
      end
      S_WR_I: begin
        mem_we    = 1'b1;
        mem_addr  = i_r;
        mem_wdata = mem_rdata;
      end
      S_WR_J: begin
        mem_we         = 1'b1;
        mem_addr       = j_r;
        mem_wdata      = held_r;
        swap_index_nxt = i_r - AW'(1);
        res_status_nxt = (i_r == AW'(1)) ? STAT_PASS_DONE : STAT_OK;
      end
      S_DRAW: res_card_nxt = mem_rdata;
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_card_nxt   = res_card_r;
          out_status_nxt = res_status_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      deck_size_r  <= DeckSizeReset;
      swap_index_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      swap_index_r <= swap_index_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) deck_size_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tuser;
      pos_r  <= in_tdata[5:0];
      card_r <= {in_tdata[11:10], in_tdata[9:6]};
      rnd_r  <= in_tdata[27:12];
    end
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    held_r       <= held_nxt;
    res_card_r   <= res_card_nxt;
    res_status_r <= res_status_nxt;
    out_card_r   <= out_card_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_card_r};
  assign out_tuser  = out_status_r;

`ifndef NO_ASSERTIONS
  a_mod_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> state_r == S_DIV)
    else $error("modulo result outside divide state");

  a_mem_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_DECODE || state_r == S_WR_I || state_r == S_WR_J))
    else $error("deck write outside load or swap");

  a_swap_below_size: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR_J |=> CW'(swap_index_r) < CW'(n_cur))
    else $error("swap index left at or beyond deck size");

  a_result_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_free) |=> state_r == S_DONE)
    else $error("result dropped while output stalled");
`endif

endmodule

### bench/testbench.sv
// Self-checking bench for deck_shuffle_engine_unit: directed and random commands
// with a local deck predictor. Depends on dse_pkg and the engine RTL.
module testbench;
  import dse_pkg::*;

  localparam int MAX_CARDS = 64;
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]      cmd;
    logic [PosW-1:0]      pos;
    logic [RankW-1:0]     rank;
    logic [SuitW-1:0]     suit;
    logic [DividendW-1:0] rnd;
  } deck_cmd_t;

  typedef struct packed {
    logic [RankW-1:0]   rank;
    logic [SuitW-1:0]   suit;
    logic [StatusW-1:0] status;
  } card_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;   // position[5:0], card_rank[9:6],
                                    // card_suit[11:10], random_value[27:12]
  logic [CmdW-1:0]      in_tuser;   // command
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;  // drawn_rank[3:0], drawn_suit[5:4]
  logic [StatusW-1:0]   out_tuser;  // status
  logic                 cfg_wr_en;
  logic [SizeW-1:0]     cfg_wr_data;

  deck_shuffle_engine_unit #(.MAX_CARDS(MAX_CARDS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // predictor state
  logic [CardW-1:0] deck_image [MAX_CARDS];
  logic [PosW-1:0]  pass_index;
  logic [SizeW-1:0] size_setting;

  deck_cmd_t    cmd_backlog [$];
  card_result_t results_due [$];
  card_result_t predicted;
  card_result_t seen;
  card_result_t wanted;
  deck_cmd_t    beat;
  int           faults;
  int           wait_left;
  int           ready_hold;
  bit           in_steady;
  bit           out_steady;

  function automatic int cards_live();
    return (size_setting > MAX_CARDS) ? MAX_CARDS : int'(size_setting);
  endfunction

  task automatic play_command(input deck_cmd_t c, output card_result_t r);
    int n, i, j;
    logic [CardW-1:0] held;
    n = cards_live();
    r = '0;
    r.status = STAT_OK;
    case (c.cmd)
      CMD_LOAD: begin
        if (c.pos >= n) r.status = STAT_RANGE;
        else begin
          deck_image[c.pos] = {c.suit, c.rank};
          pass_index = '0;
        end
      end
      CMD_SHUFFLE: begin
        if (n < 2) begin
          pass_index = '0;
          r.status = STAT_PASS_DONE;
        end else begin
          i = pass_index;
          if (i == 0 || i >= n) i = n - 1;
          j = int'(c.rnd) % (i + 1);
          held = deck_image[i];
          deck_image[i] = deck_image[j];
          deck_image[j] = held;
          pass_index = i - 1;
          if (pass_index == 0) r.status = STAT_PASS_DONE;
        end
      end
      CMD_DRAW: begin
        if (c.pos >= n) r.status = STAT_RANGE;
        else {r.suit, r.rank} = deck_image[c.pos];
      end
      default: ;
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // driver: one beat at a time from the backlog, random gap after each
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      wait_left = 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        if ($urandom_range(0, 29) == 0) in_steady = ~in_steady;
        wait_left = in_steady ? 0 : $urandom_range(0, 8);
      end
      if (wait_left > 0) begin
        wait_left--;
        in_tvalid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        beat = cmd_backlog.pop_front();
        in_tdata  <= {4'b0, beat.rnd, beat.suit, beat.rank, beat.pos};
        in_tuser  <= beat.cmd;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // predict on every accepted command beat
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      play_command({in_tuser, in_tdata[5:0], in_tdata[9:6], in_tdata[11:10],
                    in_tdata[27:12]}, predicted);
      results_due.push_back(predicted);
    end
  end

  // monitor: random back-pressure, compare each result beat
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = {out_tdata[3:0], out_tdata[5:4], out_tuser};
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result rank %0d suit %0d status %0d", $time,
                   seen.rank, seen.suit, seen.status);
          faults++;
        end else begin
          wanted = results_due.pop_front();
          if (seen.rank !== wanted.rank) begin
            $display("%0t: drawn_rank expected %0d got %0d", $time, wanted.rank, seen.rank);
            faults++;
          end
          if (seen.suit !== wanted.suit) begin
            $display("%0t: drawn_suit expected %0d got %0d", $time, wanted.suit, seen.suit);
            faults++;
          end
          if (seen.status !== wanted.status) begin
            $display("%0t: status expected %0d got %0d", $time, wanted.status, seen.status);
            faults++;
          end
        end
        if ($urandom_range(0, 29) == 0) out_steady = ~out_steady;
        ready_hold = out_steady ? 0 : $urandom_range(0, 8);
      end else if (ready_hold > 0) begin
        ready_hold--;
      end
      out_tready <= (ready_hold == 0);
    end
  end

  task automatic queue_cmd(input logic [CmdW-1:0] c, input logic [PosW-1:0] p,
                           input logic [RankW-1:0] r, input logic [SuitW-1:0] s,
                           input logic [DividendW-1:0] v);
    cmd_backlog.push_back('{cmd: c, pos: p, rank: r, suit: s, rnd: v});
  endtask

  function automatic logic [PosW-1:0] pick_pos();
    int n;
    n = cards_live();
    if (n == 0 || $urandom_range(0, 6) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, n - 1);
  endfunction

  // block idle: nothing queued, nothing in flight
  task automatic settle();
    while (cmd_backlog.size() != 0 || in_tvalid || results_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_deck_size(input logic [SizeW-1:0] v);
    settle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    size_setting = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_round(input int budget);
    int left, n, k, m;
    left = budget;
    while (left > 0) begin
      n = cards_live();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          // up to a whole pass of shuffle steps, with the odd draw mixed in
          k = (n < 2) ? 1 : n - 1;
          for (m = 0; m < k && left > 0; m++) begin
            queue_cmd(CMD_SHUFFLE, $urandom_range(0, 63), $urandom_range(0, 15),
                      $urandom_range(0, 3), $urandom_range(0, 65535));
            left--;
            if ($urandom_range(0, 5) == 0) begin
              queue_cmd(CMD_DRAW, pick_pos(), $urandom_range(0, 15), $urandom_range(0, 3),
                        $urandom_range(0, 65535));
              left--;
            end
          end
        end
        5, 6, 7: begin
          k = $urandom_range(1, 6);
          for (m = 0; m < k; m++) begin
            queue_cmd(($urandom_range(0, 3) == 0) ? CMD_LOAD : CMD_DRAW, pick_pos(),
                      $urandom_range(0, 15), $urandom_range(0, 3), $urandom_range(0, 65535));
            left--;
          end
        end
        8: begin
          queue_cmd($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 15),
                    $urandom_range(0, 3), $urandom_range(0, 65535));
          left--;
        end
        default: begin
          // load restarts the pass, often midway
          queue_cmd(CMD_LOAD, pick_pos(), $urandom_range(0, 15), $urandom_range(0, 3),
                    $urandom_range(0, 65535));
          left--;
        end
      endcase
    end
  endtask

  initial begin
    int p, r;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    faults      = 0;
    in_steady   = 1'b0;
    out_steady  = 1'b0;
    pass_index  = '0;
    size_setting = DeckSizeReset;
    foreach (deck_image[e]) deck_image[e] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset size: fill every live entry so no draw can hit an unwritten card
    for (p = 0; p < 52; p++) queue_cmd(CMD_LOAD, p, p % 16, (p / 4) % 4, '0);
    queue_cmd(CMD_LOAD, 6'd52, 4'd5, 2'd1, '0);
    queue_cmd(CMD_LOAD, 6'd63, 4'd15, 2'd3, 16'hFFFF);
    queue_cmd(CMD_DRAW, 6'd0, '0, '0, '0);
    queue_cmd(CMD_DRAW, 6'd51, '0, '0, '0);
    queue_cmd(CMD_DRAW, 6'd52, '0, '0, '0);
    queue_cmd(CMD_DRAW, 6'd63, 4'd15, 2'd3, 16'hFFFF);
    queue_cmd(CMD_UNUSED, 6'd63, 4'd15, 2'd3, 16'hFFFF);
    queue_cmd(CMD_SHUFFLE, '0, '0, '0, 16'h0000);
    queue_cmd(CMD_SHUFFLE, 6'd63, 4'd15, 2'd3, 16'hFFFF);
    queue_cmd(CMD_LOAD, 6'd0, 4'd13, 2'd3, '0);
    queue_cmd(CMD_DRAW, 6'd0, '0, '0, '0);
    queue_cmd(CMD_LOAD, 6'd51, 4'd15, 2'd2, '0);
    queue_cmd(CMD_DRAW, 6'd51, '0, '0, '0);
    queue_cmd(CMD_SHUFFLE, '0, '0, '0, 16'hFFFF);

    set_deck_size(7'd64);
    for (p = 52; p < 64; p++) queue_cmd(CMD_LOAD, p, p % 16, p % 4, '0);
    queue_cmd(CMD_DRAW, 6'd63, '0, '0, '0);
    // a full pass ends with the pass-finished flag, the next step starts afresh
    for (p = 0; p < 64; p++) queue_cmd(CMD_SHUFFLE, '0, '0, '0, $urandom_range(0, 65535));

    set_deck_size(7'd1);
    queue_cmd(CMD_SHUFFLE, '0, '0, '0, 16'hFFFF);
    queue_cmd(CMD_DRAW, 6'd0, '0, '0, '0);
    queue_cmd(CMD_DRAW, 6'd1, '0, '0, '0);
    queue_cmd(CMD_LOAD, 6'd0, 4'd12, 2'd0, '0);

    set_deck_size(7'd0);
    queue_cmd(CMD_DRAW, 6'd0, '0, '0, '0);
    queue_cmd(CMD_LOAD, 6'd0, 4'd1, 2'd1, '0);
    queue_cmd(CMD_SHUFFLE, '0, '0, '0, 16'd7);

    set_deck_size(7'd2);
    queue_cmd(CMD_SHUFFLE, '0, '0, '0, 16'd1);
    queue_cmd(CMD_SHUFFLE, '0, '0, '0, 16'd2);

    // oversize register acts as the full deck
    set_deck_size(7'd127);
    queue_cmd(CMD_DRAW, 6'd63, '0, '0, '0);
    for (p = 0; p < 10; p++) queue_cmd(CMD_SHUFFLE, '0, '0, '0, $urandom_range(0, 65535));
    // shrink mid-pass: index restarts from the new top
    set_deck_size(7'd5);
    for (p = 0; p < 6; p++) queue_cmd(CMD_SHUFFLE, '0, '0, '0, $urandom_range(0, 65535));

    for (r = 0; r < 12; r++) begin
      case (r)
        0: set_deck_size(7'd64);
        1: set_deck_size(7'd52);
        2: set_deck_size(7'd2);
        3: set_deck_size(7'd127);
        4: set_deck_size(7'd3);
        5: set_deck_size(7'd1);
        6: set_deck_size(7'd65);
        7: set_deck_size(7'd0);
        8: set_deck_size(7'd64);
        default: set_deck_size($urandom_range(1, 127));
      endcase
      random_round(148);
    end

    settle();
    repeat (40) @(posedge clk);
    if (faults == 0 && results_due.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  initial begin
    #(12 * 500000);
    $display("testbench: errors");
    $finish;
  end

endmodule
